@@ sv/bda_pkg.sv @@
// ----------------------------------------------------------------------------
// bda_pkg
// Types and constants shared by the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned STEP_W  = $clog2(VALUE_W);
    localparam int unsigned LEFT_W  = $clog2(DIGITS + 1);

    localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0]  LEFT_FULL  = LEFT_W'(DIGITS);
    localparam logic [LEFT_W-1:0]  LEFT_ONE   = LEFT_W'(1);
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ = 4'd3;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_MOVE
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

@@ sv/bda_cell.sv @@
// ----------------------------------------------------------------------------
// bda_cell
// One decimal digit of the shift-add-3 chain; also shifts its digit upward.
// ----------------------------------------------------------------------------
module bda_cell (
    input  logic                           i_clk,
    input  bda_pkg::t_cell_op              i_op,
    input  logic                           i_carry,
    input  logic [bda_pkg::DIGIT_W-1:0]    i_digit,
    output logic                           o_carry,
    output logic [bda_pkg::DIGIT_W-1:0]    o_digit
);

    logic [bda_pkg::DIGIT_W-1:0] r_digit;
    logic [bda_pkg::DIGIT_W-1:0] n_digit;
    logic [bda_pkg::DIGIT_W-1:0] w_adj;

    assign w_adj   = (r_digit >= bda_pkg::DABBLE_MIN) ? r_digit + bda_pkg::DABBLE_ADJ
                                                      : r_digit;
    assign o_carry = w_adj[bda_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        case (i_op)
            bda_pkg::CELL_CLEAR:  n_digit = '0;
            bda_pkg::CELL_DABBLE: n_digit = {w_adj[bda_pkg::DIGIT_W-2:0], i_carry};
            bda_pkg::CELL_MOVE:   n_digit = i_digit;
            default:              n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

@@ sv/binary_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 32-bit beat to decimal ASCII digits, MSD first.
// ----------------------------------------------------------------------------
// One value is taken at a time. After the input beat, a row of ten digit
// cells runs 32 shift-add-3 steps, one per cycle, then shifts leading zero
// digits out one per cycle, then presents the remaining digits one beat
// each, most significant first, with tlast on the final digit. Zero gives
// the single character '0'.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        o_m_tlast
);

    bda_pkg::t_state                     r_state;
    bda_pkg::t_state                     n_state;
    logic [bda_pkg::VALUE_W-1:0]         r_bin;
    logic [bda_pkg::VALUE_W-1:0]         n_bin;
    logic [bda_pkg::STEP_W-1:0]          r_cnt;
    logic [bda_pkg::STEP_W-1:0]          n_cnt;
    logic [bda_pkg::LEFT_W-1:0]          r_left;
    logic [bda_pkg::LEFT_W-1:0]          n_left;
    bda_pkg::t_cell_op                   w_op;
    logic                                w_carry [bda_pkg::DIGITS];
    logic [bda_pkg::DIGIT_W-1:0]         w_digit [bda_pkg::DIGITS];
    logic [bda_pkg::DIGIT_W-1:0]         w_top;
    logic [bda_pkg::CHAR_W-1:0]          w_char;

    assign w_carry[0] = r_bin[bda_pkg::VALUE_W-1];
    assign w_top      = w_digit[bda_pkg::DIGITS-1];

    for (genvar g = 0; g < bda_pkg::DIGITS; g++) begin : g_cell
        if (g == 0) begin : g_first
            bda_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_carry (w_carry[g]),
                .i_digit ('0),
                .o_carry (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end else if (g == bda_pkg::DIGITS - 1) begin : g_last
            bda_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_carry (w_carry[g]),
                .i_digit (w_digit[g-1]),
                .o_carry (),
                .o_digit (w_digit[g])
            );
        end else begin : g_mid
            bda_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_carry (w_carry[g]),
                .i_digit (w_digit[g-1]),
                .o_carry (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end
    end

    assign w_char    = bda_pkg::ASCII_ZERO + {2'b00, w_top};
    assign o_m_tdata = {2'b00, w_char};
    assign o_m_tlast = (r_left == bda_pkg::LEFT_ONE);

    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_cnt      = r_cnt;
        n_left     = r_left;
        w_op       = bda_pkg::CELL_HOLD;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_bin   = i_s_tdata;
                    n_cnt   = bda_pkg::STEP_LAST;
                    w_op    = bda_pkg::CELL_CLEAR;
                    n_state = bda_pkg::ST_CONV;
                end
            end
            bda_pkg::ST_CONV: begin
                w_op  = bda_pkg::CELL_DABBLE;
                n_bin = {r_bin[bda_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_left  = bda_pkg::LEFT_FULL;
                    n_state = bda_pkg::ST_SKIP;
                end
            end
            bda_pkg::ST_SKIP: begin
                if (w_top != '0 || r_left == bda_pkg::LEFT_ONE) begin
                    n_state = bda_pkg::ST_EMIT;
                end else begin
                    w_op   = bda_pkg::CELL_MOVE;
                    n_left = r_left - 1'b1;
                end
            end
            bda_pkg::ST_EMIT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    w_op   = bda_pkg::CELL_MOVE;
                    n_left = r_left - 1'b1;
                    if (r_left == bda_pkg::LEFT_ONE) begin
                        n_state = bda_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = bda_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_left <= n_left;
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in on the slave stream; each one is predicted as a list of
// ASCII digit beats, most significant first, tlast on the final one. Every
// digit beat leaving the master stream is compared with the oldest predicted
// beat. Directed corner values come first, then random values of every decimal
// length. The bench then runs a long output hold-off that backs up the input,
// and sends with full drain between values. The sender idles in bursts and
// the receiver stalls at random or on its own rotating pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [bda_pkg::CHAR_W-1:0] digit_char;
        logic                       is_last;
    } t_digit_beat;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    t_digit_beat    digit_q[$];
    int unsigned    error_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left  = 1;
    t_rx_mode       rx_mode     = RX_OPEN;
    logic [15:0]    rx_pattern  = 16'hFFFF;
    bit             hold_req    = 1'b0;
    int unsigned    hold_left   = 0;

    binary_to_decimal_ascii DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Decimal expansion of one value, pushed as expected digit beats
    function automatic void predict_digits(input logic [31:0] value);
        logic [3:0]  dec[bda_pkg::DIGITS];
        logic [31:0] rest;
        int          n;
        rest = value;
        n = 0;
        if (rest == '0) begin
            digit_q.push_back('{digit_char: bda_pkg::ASCII_ZERO, is_last: 1'b1});
            return;
        end
        while (rest != '0 && n < bda_pkg::DIGITS) begin
            dec[n] = 4'(rest % 10);
            rest   = rest / 10;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            digit_q.push_back('{digit_char: bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(dec[k]),
                                is_last: (k == 0)});
        end
    endfunction

    function automatic void report_error(input string what, input logic [7:0] exp_data,
                                         input logic exp_last);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch (%s) at cycle %0d: expected data %h last %b, got data %h last %b",
                     what, cycle_count, exp_data, exp_last, o_m_tdata, o_m_tlast);
        end
    endfunction

    // Predict on each accepted value, compare each accepted digit beat
    always @(posedge i_clk) begin
        t_digit_beat want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_digits(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (digit_q.size() == 0) begin
                    report_error("unexpected beat", 8'hxx, 1'bx);
                end else begin
                    want = digit_q.pop_front();
                    if (o_m_tdata !== {2'b00, want.digit_char} ||
                        o_m_tlast !== want.is_last) begin
                        report_error("digit", {2'b00, want.digit_char}, want.is_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise open, random or rotating pattern
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    i_m_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    i_m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_m_tready <= rx_pattern[0];
                    rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
    end

    task automatic send_value(input logic [31:0] value);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles == 0) return;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Send in bursts of random length; max_gap of zero sends back to back
    task automatic send_values(input logic [31:0] values[$], input int unsigned max_gap);
        foreach (values[i]) begin
            send_value(values[i]);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 6);
                if (max_gap > 0) idle_sender($urandom_range(1, max_gap));
            end
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (digit_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned span;
        longint unsigned pow10;
        int unsigned     n;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                n  = $urandom_range(1, bda_pkg::DIGITS);
                lo = 1;
                repeat (n - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                span = hi - lo + 1;
                return 32'(lo + ({$urandom, $urandom} % span));
            end
            2: return $urandom_range(0, 99);
            3: begin
                pow10 = 1;
                repeat ($urandom_range(0, bda_pkg::DIGITS - 1)) pow10 = pow10 * 10;
                return 32'(pow10 + $urandom_range(0, 2) - 1);
            end
            4: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom & ((32'h1 << $urandom_range(0, 31)) - 1);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] values[$];
        values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                   32'd1000, 32'd65535, 32'd99999, 32'd1000000, 32'd999999999,
                   32'd1000000000, 32'd1234567890, 32'd2147483647, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        rx_mode = RX_OPEN;
        send_values(values, 0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] values[$];
        repeat (100) values.push_back(random_value());
        rx_mode    = RX_RANDOM;
        send_values(values[0:39], 50);
        rx_pattern = 16'b1100_1110_1011_0111;
        rx_mode    = RX_PATTERN;
        send_values(values[40:79], 50);
        rx_mode    = RX_OPEN;
        send_values(values[80:99], 0);
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        logic [31:0] values[$];
        repeat (6) values.push_back(random_value());
        values[0] = 32'hFFFF_FFFF;
        rx_mode  = RX_RANDOM;
        hold_req = 1'b1;
        send_values(values, 0);
        wait_drained();
    endtask

    task automatic test_drain_between();
        logic [31:0] value;
        rx_mode = RX_RANDOM;
        repeat (8) begin
            value = random_value();
            send_value(value);
            wait_drained();
            idle_sender($urandom_range(1, 45));
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        test_output_holdoff();
        test_drain_between();
        if (digit_q.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
